@@ rtl/odc_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package odc_pkg;

    localparam int SAMPLE_W  = 24;
    localparam int PROD_W    = 2 * SAMPLE_W;
    localparam int ADD_W     = PROD_W + 2;
    localparam int SUM_W     = 64;
    localparam int IDX_W     = 16;
    localparam int PCOUNT_W  = IDX_W + 1;
    localparam int MODE_W    = 2;
    localparam int CFG_IDX_W = 2;
    localparam int NUM_SUMS  = 5;

    localparam int SUM_DENS = 0;
    localparam int SUM_TAU  = 4;

    localparam logic [CFG_IDX_W-1:0] REG_DENSITY_MODE = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_POINT_COUNT  = CFG_IDX_W'(1);

    localparam logic [MODE_W-1:0] MODE_PLAIN = MODE_W'(0);
    localparam logic [MODE_W-1:0] MODE_GRAD  = MODE_W'(1);
    localparam logic [MODE_W-1:0] MODE_TAU   = MODE_W'(2);

    typedef logic [3:0][SAMPLE_W-1:0]       sample_vec_t;
    typedef logic [NUM_SUMS-1:0][ADD_W-1:0] addend_vec_t;
    typedef logic [NUM_SUMS-1:0][SUM_W-1:0] sum_vec_t;

    typedef struct packed {
        logic consume;
        logic last;
    } acc_ctrl_t;

    typedef struct packed {
        sum_vec_t         sums;
        logic             clip;
        logic [IDX_W-1:0] index;
    } point_total_t;

    typedef struct packed {
        logic [SUM_W-1:0] value;
        logic             clip;
    } sat_t;

    // b is already sign-extended to SUM_W+1 bits
    function automatic sat_t sat_add(logic [SUM_W-1:0] a, logic [SUM_W:0] b);
        logic [SUM_W:0] s;
        sat_t           r;
        s      = {a[SUM_W-1], a} + b;
        r.clip = s[SUM_W] ^ s[SUM_W-1];
        if (r.clip)
        begin
            r.value = s[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
        end
        else
        begin
            r.value = s[SUM_W-1:0];
        end
        return r;
    endfunction

endpackage

`default_nettype wire

@@ rtl/odc_prod.sv @@
`timescale 1ns / 1ps
`default_nettype none

module odc_prod
    import odc_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        load,
    input  wire sample_vec_t bra,
    input  wire sample_vec_t ket,
    output addend_vec_t      addend
);

    logic signed [PROD_W-1:0] dens_p;
    logic signed [PROD_W-1:0] bk [3];
    logic signed [PROD_W-1:0] kb [3];
    logic signed [PROD_W-1:0] dd [3];
    addend_vec_t              addend_next;
    addend_vec_t              addend_reg;

    always_comb
    begin
        dens_p = $signed(bra[0]) * $signed(ket[0]);
        for (int i = 1; i < 4; i++)
        begin
            bk[i-1] = $signed(bra[0]) * $signed(ket[i]);
            kb[i-1] = $signed(ket[0]) * $signed(bra[i]);
            dd[i-1] = $signed(bra[i]) * $signed(ket[i]);
        end
        addend_next[SUM_DENS] = ADD_W'(dens_p);
        for (int i = 1; i < 4; i++)
        begin
            addend_next[i] = ADD_W'(bk[i-1]) + ADD_W'(kb[i-1]);
        end
        addend_next[SUM_TAU] = ADD_W'(dd[0]) + ADD_W'(dd[1]) + ADD_W'(dd[2]);
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            addend_reg <= addend_next;
        end
    end

    assign addend = addend_reg;

endmodule

`default_nettype wire

@@ rtl/odc_accum.sv @@
`timescale 1ns / 1ps
`default_nettype none

module odc_accum
    import odc_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire acc_ctrl_t           ctrl,
    input  wire addend_vec_t         addend,
    input  wire logic [PCOUNT_W-1:0] point_count,
    output point_total_t             total
);

    sum_vec_t           sum_reg;
    sum_vec_t           sum_add;
    logic               clip_reg;
    logic               any_clip;
    logic [IDX_W-1:0]   cnt_reg;
    logic [IDX_W-1:0]   cnt_next;
    logic [PCOUNT_W-1:0] cnt_inc;
    sat_t               r [NUM_SUMS];
    point_total_t       total_reg;

    always_comb
    begin
        any_clip = 1'b0;
        for (int i = 0; i < NUM_SUMS; i++)
        begin
            r[i] = sat_add(sum_reg[i],
                           {{(SUM_W+1-ADD_W){addend[i][ADD_W-1]}}, addend[i]});
            sum_add[i] = r[i].value;
            any_clip   = any_clip | r[i].clip;
        end
    end

    // wrap to zero at point_count (zero acts as one) or past the index range
    always_comb
    begin
        cnt_inc = {1'b0, cnt_reg} + PCOUNT_W'(1);
        if (cnt_inc >= point_count || cnt_inc[IDX_W])
        begin
            cnt_next = '0;
        end
        else
        begin
            cnt_next = cnt_inc[IDX_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg  <= '0;
            clip_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (ctrl.consume)
        begin
            if (ctrl.last)
            begin
                sum_reg  <= '0;
                clip_reg <= 1'b0;
                cnt_reg  <= cnt_next;
            end
            else
            begin
                sum_reg  <= sum_add;
                clip_reg <= clip_reg | any_clip;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.consume && ctrl.last)
        begin
            total_reg.sums  <= sum_add;
            total_reg.clip  <= clip_reg | any_clip;
            total_reg.index <= cnt_reg;
        end
    end

    assign total = total_reg;

endmodule

`default_nettype wire

@@ rtl/odc_out.sv @@
`timescale 1ns / 1ps
`default_nettype none

module odc_out
    import odc_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              load,
    input  wire logic [MODE_W-1:0] mode,
    input  wire point_total_t      total,
    output logic [SUM_W-1:0]       density,
    output logic [SUM_W-1:0]       grad_x,
    output logic [SUM_W-1:0]       grad_y,
    output logic [SUM_W-1:0]       grad_z,
    output logic [SUM_W-1:0]       tau,
    output logic [IDX_W-1:0]       point_index,
    output logic                   saturated
);

    sat_t             dbl [4];
    logic             dbl_clip;
    sum_vec_t         res_next;
    logic             sat_next;
    sum_vec_t         res_reg;
    logic [IDX_W-1:0] index_reg;
    logic             sat_reg;

    always_comb
    begin
        dbl_clip = 1'b0;
        for (int i = 0; i < 4; i++)
        begin
            dbl[i]   = sat_add(total.sums[i], {total.sums[i][SUM_W-1], total.sums[i]});
            dbl_clip = dbl_clip | dbl[i].clip;
        end
    end

    always_comb
    begin
        res_next = '0;
        sat_next = total.clip;
        unique case (mode)
            MODE_PLAIN:
            begin
                res_next[SUM_DENS] = total.sums[SUM_DENS];
            end
            MODE_GRAD:
            begin
                for (int i = 0; i < 4; i++)
                begin
                    res_next[i] = dbl[i].value;
                end
                sat_next = total.clip | dbl_clip;
            end
            default:
            begin
                for (int i = 0; i < 4; i++)
                begin
                    res_next[i] = dbl[i].value;
                end
                res_next[SUM_TAU] = total.sums[SUM_TAU];
                sat_next = total.clip | dbl_clip;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            res_reg   <= res_next;
            index_reg <= total.index;
            sat_reg   <= sat_next;
        end
    end

    assign density     = res_reg[SUM_DENS];
    assign grad_x      = res_reg[1];
    assign grad_y      = res_reg[2];
    assign grad_z      = res_reg[3];
    assign tau         = res_reg[SUM_TAU];
    assign point_index = index_reg;
    assign saturated   = sat_reg;

endmodule

`default_nettype wire

@@ rtl/orbital_density_contraction.sv @@
// channel   direction  handshake               payload
// in        sink       in_valid / in_ready     bra_*, ket_*, last_orbital
// out       source     out_valid / out_ready   density, grad_*, tau, point_index, saturated
// cfg       sink       cfg_valid / cfg_ready   cfg_index, cfg_data
//
// One request per cycle unless output stalls; ten multipliers feed five saturating accumulators.
// A point's result passes the input, product, accumulator total and output registers in turn.
// Reset: sums, clip flag and point counter zero; mode 2, point count 1. cfg_ready is always high.
// A stalled result holds in the output register; orbitals not marked last keep flowing
// until another last orbital reaches the accumulators.
`timescale 1ns / 1ps
`default_nettype none

module orbital_density_contraction
    import odc_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    output logic                      in_ready,
    input  wire logic [SAMPLE_W-1:0]  bra_value,
    input  wire logic [SAMPLE_W-1:0]  bra_dx,
    input  wire logic [SAMPLE_W-1:0]  bra_dy,
    input  wire logic [SAMPLE_W-1:0]  bra_dz,
    input  wire logic [SAMPLE_W-1:0]  ket_value,
    input  wire logic [SAMPLE_W-1:0]  ket_dx,
    input  wire logic [SAMPLE_W-1:0]  ket_dy,
    input  wire logic [SAMPLE_W-1:0]  ket_dz,
    input  wire logic                 last_orbital,
    output logic                      out_valid,
    input  wire logic                 out_ready,
    output logic [SUM_W-1:0]          density,
    output logic [SUM_W-1:0]          grad_x,
    output logic [SUM_W-1:0]          grad_y,
    output logic [SUM_W-1:0]          grad_z,
    output logic [SUM_W-1:0]          tau,
    output logic [IDX_W-1:0]          point_index,
    output logic                      saturated,
    input  wire logic                 cfg_valid,
    output logic                      cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [PCOUNT_W-1:0]  cfg_data
);

    logic [MODE_W-1:0]   mode_reg;
    logic [PCOUNT_W-1:0] pcount_reg;

    sample_vec_t bra_reg;
    sample_vec_t ket_reg;
    logic        last1_reg;
    logic        v1_reg;
    logic        v2_reg;
    logic        last2_reg;
    logic        v3_reg;
    logic        out_valid_reg;

    logic        in_accept;
    logic        s1_move;
    logic        s2_consume;
    logic        s2_free;
    logic        s3_free;
    logic        s3_move;
    logic        out_free;

    acc_ctrl_t    acc_ctrl;
    addend_vec_t  addend;
    point_total_t total;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= MODE_TAU;
            pcount_reg <= PCOUNT_W'(1);
        end
        else if (cfg_valid)
        begin
            if (cfg_index == REG_DENSITY_MODE)
            begin
                mode_reg <= cfg_data[MODE_W-1:0];
            end
            else if (cfg_index == REG_POINT_COUNT)
            begin
                pcount_reg <= cfg_data;
            end
        end
    end

    assign out_free   = !out_valid_reg || out_ready;
    assign s3_move    = v3_reg && out_free;
    assign s3_free    = !v3_reg || out_free;
    assign s2_consume = v2_reg && (!last2_reg || s3_free);
    assign s2_free    = !v2_reg || s2_consume;
    assign s1_move    = v1_reg && s2_free;
    assign in_ready   = !v1_reg || s2_free;
    assign in_accept  = in_valid && in_ready;

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            bra_reg   <= {bra_dz, bra_dy, bra_dx, bra_value};
            ket_reg   <= {ket_dz, ket_dy, ket_dx, ket_value};
            last1_reg <= last_orbital;
        end
        if (s1_move)
        begin
            last2_reg <= last1_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            v3_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_accept)
            begin
                v1_reg <= 1'b1;
            end
            else if (s1_move)
            begin
                v1_reg <= 1'b0;
            end

            if (s1_move)
            begin
                v2_reg <= 1'b1;
            end
            else if (s2_consume)
            begin
                v2_reg <= 1'b0;
            end

            if (s2_consume && last2_reg)
            begin
                v3_reg <= 1'b1;
            end
            else if (s3_move)
            begin
                v3_reg <= 1'b0;
            end

            if (s3_move)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid        = out_valid_reg;
    assign acc_ctrl.consume = s2_consume;
    assign acc_ctrl.last    = last2_reg;

    odc_prod u_prod (
        .clk    (clk),
        .load   (s1_move),
        .bra    (bra_reg),
        .ket    (ket_reg),
        .addend (addend)
    );

    odc_accum u_accum (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctrl        (acc_ctrl),
        .addend      (addend),
        .point_count (pcount_reg),
        .total       (total)
    );

    odc_out u_out (
        .clk         (clk),
        .load        (s3_move),
        .mode        (mode_reg),
        .total       (total),
        .density     (density),
        .grad_x      (grad_x),
        .grad_y      (grad_y),
        .grad_z      (grad_z),
        .tau         (tau),
        .point_index (point_index),
        .saturated   (saturated)
    );

    a_empty_ready: assert property (@(posedge clk) disable iff (!rst_n)
        (!v1_reg && !v2_reg && !v3_reg && !out_valid_reg) |-> in_ready)
        else $error("pipeline empty but input not ready");

    a_last_held: assert property (@(posedge clk) disable iff (!rst_n)
        (v2_reg && last2_reg && !s3_free) |=> (v2_reg && last2_reg))
        else $error("last orbital dropped while result stage full");

    a_total_held: assert property (@(posedge clk) disable iff (!rst_n)
        (v3_reg && !out_free) |=> v3_reg)
        else $error("point total lost while output stalled");

endmodule

`default_nettype wire
